### sv/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros sample on clk and are
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ALG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ALG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ALG_ASSERT_IMPLY(lbl, ante, cons, msg)
`define ALG_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### sv/alg_pkg.sv
`default_nettype none

package alg_pkg;

  localparam int MAX_WORDS = 32;
  localparam int WORD_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_WORDS);
  localparam int LEN_W     = 6;
  localparam int IDX_W     = 5;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EMIT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEN_SRC     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_TGT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_IS_SRC = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONSECUTIVE = 2'd3;

  typedef logic [WORD_W-1:0] mask_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_item;
    logic clear_links;
    logic add_rd;
    logic add_wr;
    logic emit_init;
    logic idx_clr;
    logic idx_inc;
    logic seed;
    logic scan_start;
    logic scan_run;
    logic apply;
    logic step2;
    logic emit_group;
    logic emit_single;
    logic emit_empty;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             add_ok;
    logic             both_zero;
    logic             walk_end;
    logic             walk_skip;
    logic             other_end;
    logic             other_skip;
    logic             scan_done;
    logic             changed;
    logic             last_group;
    logic             last_single;
    logic             out_free;
  } dp_sts_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
    return (n > LEN_W'(MAX_WORDS)) ? LEN_W'(MAX_WORDS) : n;
  endfunction

  function automatic mask_t low_mask(input logic [LEN_W-1:0] n);
    mask_t m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (LEN_W'(i) < n);
    end
    return m;
  endfunction

  function automatic mask_t bit_at(input logic [IDX_W-1:0] idx);
    return mask_t'(1) << idx;
  endfunction

  // Fill every bit between the lowest and highest set bit.
  function automatic mask_t span_fill(input mask_t x);
    mask_t up;
    mask_t dn;
    up = x;
    dn = x;
    for (int k = 0; k < $clog2(WORD_W); k++) begin
      up = up | (up << (1 << k));
      dn = dn | (dn >> (1 << k));
    end
    return up & dn;
  endfunction

endpackage

`default_nettype wire

### sv/alg_ram.sv
`default_nettype none

module alg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/alg_dp.sv
`default_nettype none

module alg_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [alg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [alg_pkg::LEN_W-1:0]     cfg_data,
  input  wire logic [alg_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [alg_pkg::IDX_W-1:0]     in_src_index,
  input  wire logic [alg_pkg::IDX_W-1:0]     in_tgt_index,
  input  wire alg_pkg::dp_cmd_t              dp_cmd,
  output alg_pkg::dp_sts_t                   dp_sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [alg_pkg::WORD_W-1:0]         out_src_group_mask,
  output logic [alg_pkg::WORD_W-1:0]         out_tgt_group_mask,
  output logic                               out_last
);

  import alg_pkg::*;

  logic [LEN_W-1:0]  len_src_r, len_tgt_r;
  logic              side_is_src_r, consec_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [IDX_W-1:0]  src_idx_r, tgt_idx_r;
  logic [MAX_WORDS-1:0] vld_r;
  logic              rv_r;
  logic              rd_pend_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic [LEN_W-1:0]  r_cnt_r;
  logic [LEN_W-1:0]  idx_r;
  mask_t             acc_r, acc_nxt;
  mask_t             gs_r, gt_r, done_s_r, done_t_r;
  logic              out_valid_r, out_last_r;
  mask_t             out_src_r, out_tgt_r;

  logic [LEN_W-1:0]  ls, lt, walk_len, other_len;
  mask_t             svalid, tvalid, done_w, done_o;
  logic              from_src, pass_a, issue, out_load;
  logic [ADDR_W-1:0] raddr;
  mask_t             rdata, row, wdata;
  mask_t             new_s, new_t, single_s, single_t, idx_bit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_src_r     <= '0;
      len_tgt_r     <= '0;
      side_is_src_r <= 1'b1;
      consec_r      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEN_SRC:     len_src_r     <= cfg_data;
        REG_LEN_TGT:     len_tgt_r     <= cfg_data;
        REG_SIDE_IS_SRC: side_is_src_r <= cfg_data[0];
        REG_CONSECUTIVE: consec_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ls        = eff_len(len_src_r);
  assign lt        = eff_len(len_tgt_r);
  assign svalid    = low_mask(ls);
  assign tvalid    = low_mask(lt);
  assign from_src  = side_is_src_r;
  assign walk_len  = from_src ? ls : lt;
  assign other_len = from_src ? lt : ls;
  assign done_w    = from_src ? done_s_r : done_t_r;
  assign done_o    = from_src ? done_t_r : done_s_r;
  assign pass_a    = from_src ^ dp_cmd.step2;
  assign idx_bit   = bit_at(idx_r[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (dp_cmd.take_item) begin
      cmd_r     <= in_cmd;
      src_idx_r <= in_src_index;
      tgt_idx_r <= in_tgt_index;
    end
  end

  // Link rows: RAM plus one valid bit per row, so clear resets only the valid bits.
  assign issue = dp_cmd.scan_run && (r_cnt_r < ls);
  assign raddr = dp_cmd.add_rd ? ADDR_W'(src_idx_r) : r_cnt_r[ADDR_W-1:0];
  assign row   = rv_r ? rdata : '0;
  assign wdata = row | bit_at(tgt_idx_r);

  alg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WORDS)
  ) u_links (
    .clk   (clk),
    .we    (dp_cmd.add_wr),
    .waddr (ADDR_W'(src_idx_r)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (dp_cmd.clear_links) begin
      vld_r <= '0;
    end else if (dp_cmd.add_wr) begin
      vld_r[ADDR_W'(src_idx_r)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rv_r <= vld_r[raddr];
    if (issue) begin
      rd_idx_r <= r_cnt_r[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      r_cnt_r   <= '0;
    end else if (dp_cmd.scan_start) begin
      rd_pend_r <= 1'b0;
      r_cnt_r   <= '0;
    end else begin
      rd_pend_r <= issue;
      if (issue) begin
        r_cnt_r <= r_cnt_r + LEN_W'(1);
      end
    end
  end

  // Row to target: OR in rows of group source words.
  // Target to row: mark the row if it hits a group target word.
  always_comb begin
    acc_nxt = acc_r;
    if (pass_a) begin
      if (gs_r[rd_idx_r]) begin
        acc_nxt = acc_r | row;
      end
    end else if (|(row & gt_r)) begin
      acc_nxt = acc_r | bit_at(IDX_W'(rd_idx_r));
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.scan_start) begin
      acc_r <= '0;
    end else if (rd_pend_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    new_t = gt_r | (acc_r & tvalid);
    new_s = gs_r | (acc_r & svalid);
    if (dp_cmd.step2 && consec_r) begin
      new_t = new_t | span_fill(new_t);
      new_s = new_s | span_fill(new_s);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.seed) begin
      gs_r <= from_src ? idx_bit : '0;
      gt_r <= from_src ? '0 : idx_bit;
    end else if (dp_cmd.apply) begin
      if (pass_a) begin
        gt_r <= new_t;
      end else begin
        gs_r <= new_s;
      end
    end
  end

  assign single_s = from_src ? '0 : idx_bit;
  assign single_t = from_src ? idx_bit : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_s_r <= '0;
      done_t_r <= '0;
      idx_r    <= '0;
    end else begin
      if (dp_cmd.emit_init) begin
        done_s_r <= '0;
        done_t_r <= '0;
      end else if (dp_cmd.emit_group) begin
        done_s_r <= done_s_r | gs_r;
        done_t_r <= done_t_r | gt_r;
      end else if (dp_cmd.emit_single) begin
        done_s_r <= done_s_r | single_s;
        done_t_r <= done_t_r | single_t;
      end
      if (dp_cmd.idx_clr) begin
        idx_r <= '0;
      end else if (dp_cmd.idx_inc) begin
        idx_r <= idx_r + LEN_W'(1);
      end
    end
  end

  // Output register.
  assign out_load = dp_cmd.emit_group | dp_cmd.emit_single | dp_cmd.emit_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit_group) begin
      out_src_r  <= gs_r;
      out_tgt_r  <= gt_r;
      out_last_r <= dp_sts.last_group;
    end else if (dp_cmd.emit_single) begin
      out_src_r  <= single_s;
      out_tgt_r  <= single_t;
      out_last_r <= dp_sts.last_single;
    end else if (dp_cmd.emit_empty) begin
      out_src_r  <= '0;
      out_tgt_r  <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_src_group_mask = out_src_r;
  assign out_tgt_group_mask = out_tgt_r;
  assign out_last           = out_last_r;

  always_comb begin
    dp_sts.item_cmd    = cmd_r;
    dp_sts.add_ok      = (LEN_W'(src_idx_r) < ls) && (LEN_W'(tgt_idx_r) < lt);
    dp_sts.both_zero   = (ls == '0) && (lt == '0);
    dp_sts.walk_end    = (idx_r >= walk_len);
    dp_sts.walk_skip   = done_w[idx_r[IDX_W-1:0]];
    dp_sts.other_end   = (idx_r >= other_len);
    dp_sts.other_skip  = done_o[idx_r[IDX_W-1:0]];
    dp_sts.scan_done   = (r_cnt_r >= ls) && !rd_pend_r;
    dp_sts.changed     = pass_a ? (new_t != gt_r) : (new_s != gs_r);
    dp_sts.last_group  = ((~(done_s_r | gs_r) & svalid) == '0) &&
                         ((~(done_t_r | gt_r) & tvalid) == '0);
    dp_sts.last_single = ((~(done_s_r | single_s) & svalid) == '0) &&
                         ((~(done_t_r | single_t) & tvalid) == '0);
    dp_sts.out_free    = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

### sv/alg_ctrl.sv
`default_nettype none

module alg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire alg_pkg::dp_sts_t dp_sts,
  output alg_pkg::dp_cmd_t      dp_cmd
);

  import alg_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_ADD_RD = 4'd2;
  localparam logic [3:0] S_ADD_WR = 4'd3;
  localparam logic [3:0] S_EMPTY  = 4'd4;
  localparam logic [3:0] S_WALK   = 4'd5;
  localparam logic [3:0] S_PSTART = 4'd6;
  localparam logic [3:0] S_PASS   = 4'd7;
  localparam logic [3:0] S_PEND   = 4'd8;
  localparam logic [3:0] S_GROUP  = 4'd9;
  localparam logic [3:0] S_OTHER  = 4'd10;
  localparam logic [3:0] S_SINGLE = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       step2_r, step2_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    dp_cmd       = '0;
    dp_cmd.step2 = step2_r;
    state_nxt    = state_r;
    step2_nxt    = step2_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.take_item = 1'b1;
          state_nxt        = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (dp_sts.item_cmd)
          CMD_CLEAR: begin
            dp_cmd.clear_links = 1'b1;
            state_nxt          = S_IDLE;
          end
          CMD_ADD: begin
            state_nxt = dp_sts.add_ok ? S_ADD_RD : S_IDLE;
          end
          CMD_EMIT: begin
            dp_cmd.emit_init = 1'b1;
            dp_cmd.idx_clr   = 1'b1;
            state_nxt        = dp_sts.both_zero ? S_EMPTY : S_WALK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ADD_RD: begin
        dp_cmd.add_rd = 1'b1;
        state_nxt     = S_ADD_WR;
      end
      S_ADD_WR: begin
        dp_cmd.add_wr = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_EMPTY: begin
        if (dp_sts.out_free) begin
          dp_cmd.emit_empty = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_WALK: begin
        if (dp_sts.walk_end) begin
          dp_cmd.idx_clr = 1'b1;
          state_nxt      = S_OTHER;
        end else if (dp_sts.walk_skip) begin
          dp_cmd.idx_inc = 1'b1;
        end else begin
          dp_cmd.seed = 1'b1;
          step2_nxt   = 1'b0;
          state_nxt   = S_PSTART;
        end
      end
      S_PSTART: begin
        dp_cmd.scan_start = 1'b1;
        state_nxt         = S_PASS;
      end
      S_PASS: begin
        dp_cmd.scan_run = 1'b1;
        if (dp_sts.scan_done) begin
          state_nxt = S_PEND;
        end
      end
      S_PEND: begin
        dp_cmd.apply = 1'b1;
        if (dp_sts.changed) begin
          step2_nxt = !step2_r;
          state_nxt = S_PSTART;
        end else begin
          state_nxt = S_GROUP;
        end
      end
      S_GROUP: begin
        if (dp_sts.out_free) begin
          dp_cmd.emit_group = 1'b1;
          dp_cmd.idx_inc    = 1'b1;
          state_nxt         = dp_sts.last_group ? S_IDLE : S_WALK;
        end
      end
      S_OTHER: begin
        if (dp_sts.other_end) begin
          state_nxt = S_IDLE;
        end else if (dp_sts.other_skip) begin
          dp_cmd.idx_inc = 1'b1;
        end else begin
          state_nxt = S_SINGLE;
        end
      end
      S_SINGLE: begin
        if (dp_sts.out_free) begin
          dp_cmd.emit_single = 1'b1;
          dp_cmd.idx_inc     = 1'b1;
          state_nxt          = dp_sts.last_single ? S_IDLE : S_OTHER;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step2_r <= step2_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/alignment_link_grouper_top.sv
// Alignment link grouper: word-alignment links in, connected groups out.
// Input channel (in_valid/in_ready) takes one request: clear all links, add
// one (source, target) link, or emit groups. Results leave on the output
// channel (out_valid/out_ready) as a source mask, a target mask and a last
// flag on the final group of an emit. cfg_* writes the lengths, the walking
// side and the consecutive mode; it is always ready. It is to be written by
// the user only while idle; the block itself does not enforce this. An add
// is a read-modify-write of one link row in the link RAM. An emit walks the
// words of the chosen side; every closure pass scans the link rows one per
// cycle through the RAM read port. An unlinked word needs one pass, a linked
// one two or more. Skipped words are stepped over, and unlinked other-side
// words leave as single-word groups. The next request is accepted once the
// last result sits in the output register. Reset empties the link store at
// once (one valid bit per row), restores the configuration defaults and drops
// any held result. When the receiver stalls, the result is held in the output
// register and the grouping sequencer waits before loading the next one;
// nothing is dropped.
`default_nettype none

`include "assert_macros.svh"

module alignment_link_grouper_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [alg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [alg_pkg::LEN_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [alg_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [alg_pkg::IDX_W-1:0]     in_src_index,
  input  wire logic [alg_pkg::IDX_W-1:0]     in_tgt_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [alg_pkg::WORD_W-1:0]         out_src_group_mask,
  output logic [alg_pkg::WORD_W-1:0]         out_tgt_group_mask,
  output logic                               out_last
);

  import alg_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer: decodes each request and steps the group closure.
  alg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dp_sts   (dp_sts),
    .dp_cmd   (dp_cmd)
  );

  // Link store, group masks, bookkeeping and output register.
  alg_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cmd             (in_cmd),
    .in_src_index       (in_src_index),
    .in_tgt_index       (in_tgt_index),
    .dp_cmd             (dp_cmd),
    .dp_sts             (dp_sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_src_group_mask (out_src_group_mask),
    .out_tgt_group_mask (out_tgt_group_mask),
    .out_last           (out_last)
  );

  // Never overwrite a result that the receiver has not taken.
  `ALG_ASSERT_IMPLY(a_load_when_free,
    dp_cmd.emit_group || dp_cmd.emit_single || dp_cmd.emit_empty,
    dp_sts.out_free, "result loaded over a pending result")
  // An accepted request leaves idle for decode.
  `ALG_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready held after accept")
  // Row read is always followed by the row write of an add.
  `ALG_ASSERT_NEXT(a_add_rmw, dp_cmd.add_rd, dp_cmd.add_wr, "add read without write")
  // A result only appears after a load from the sequencer.
  `ALG_ASSERT_NEXT(a_no_phantom,
    !out_valid && !(dp_cmd.emit_group || dp_cmd.emit_single || dp_cmd.emit_empty),
    !out_valid, "result without load")

endmodule

`default_nettype wire
